@@ design/pbec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pbec_pkg;

  localparam int unsigned PRBS_W  = 9;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned WARM_W  = 8;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 1;

  localparam int unsigned MAX_BLOCK_BITS = 65536;
  localparam int unsigned CNT_MAX        = (1 << CNT_W) - 1;

  // Block error count saturates at the block length, limited by the field width.
  localparam logic [CNT_W-1:0] ERR_CAP =
      CNT_W'((MAX_BLOCK_BITS > CNT_MAX) ? CNT_MAX : MAX_BLOCK_BITS);

  localparam logic [WARM_W-1:0] WARMUP_RESET = WARM_W'(10);
  localparam logic [TOT_W-1:0]  TOT_MAX      = '1;

  // Feedback taps of x^9 + x^5 + 1.
  localparam int unsigned TAP_LO = 4;
  localparam int unsigned TAP_HI = 8;

  typedef enum logic [APB_AW-1:0] {
    ADDR_WARMUP = 1'b0
  } reg_addr_e;

endpackage

`default_nettype wire

@@ design/pbec_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface pbec_in_if;
  import pbec_pkg::*;

  logic              valid;
  logic              ready;
  logic              rx_bit;
  logic [PRBS_W-1:0] block_seed;
  logic              first_of_block;
  logic              last_of_block;

  modport source (
    output valid, rx_bit, block_seed, first_of_block, last_of_block,
    input  ready
  );
  modport sink (
    input  valid, rx_bit, block_seed, first_of_block, last_of_block,
    output ready
  );
endinterface

interface pbec_out_if;
  import pbec_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] block_errors;
  logic             block_counted;
  logic [TOT_W-1:0] total_errors;
  logic [TOT_W-1:0] counted_blocks;

  modport source (
    output valid, block_errors, block_counted, total_errors, counted_blocks,
    input  ready
  );
  modport sink (
    input  valid, block_errors, block_counted, total_errors, counted_blocks,
    output ready
  );
endinterface

`default_nettype wire

@@ design/prbs9_bit_error_checker_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake            Beat contents
// in_ch_i    in   valid/ready          rx_bit, block_seed, first_of_block, last_of_block
// out_ch_o   out  valid/ready          block_errors, block_counted, total_errors,
//                                      counted_blocks (one beat per closed block)
// apb        in   psel/penable/pwrite  warmup_blocks at byte address 0
//
// One bit is taken per cycle while no closing bit waits on a stalled result; a bit
// is registered, then one LFSR step, compare and saturating add load the result
// register, which offers the result. Reset clears the LFSR, counters and totals and
// loads warm-up to 10.
// A result stalled on out_ch_o holds one beat; the input stage then keeps taking
// bits that close no block and stops only at the next closing bit.

module prbs9_bit_error_checker_unit
  import pbec_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  pbec_in_if.sink            in_ch_i,
  pbec_out_if.source         out_ch_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [APB_AW-1:0]   paddr,
  input  wire [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  // Input register stage.
  logic              s1_v_q;
  logic              s1_rx_q;
  logic [PRBS_W-1:0] s1_seed_q;
  logic              s1_first_q;
  logic              s1_last_q;

  // Block state.
  logic [PRBS_W-1:0] prbs_q, prbs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WARM_W-1:0] warm_q;
  logic [WARM_W-1:0] skip_q, skip_d;
  logic [TOT_W-1:0]  err_tot_q, err_tot_d;
  logic [TOT_W-1:0]  blk_tot_q, blk_tot_d;

  // Result register.
  logic              ov_q;
  logic [CNT_W-1:0]  o_err_q;
  logic              o_cnt_q;

  logic              out_free;
  logic              s1_go;
  logic              cfg_wr;
  logic [PRBS_W-1:0] reg_cur;
  logic              ref_bit;
  logic [CNT_W-1:0]  cnt_base;
  logic [CNT_W-1:0]  cnt_new;
  logic              counted;
  logic [TOT_W:0]    err_sum;
  logic [TOT_W:0]    blk_sum;

  assign out_free = !ov_q || out_ch_o.ready;
  // Bits that close no block never wait for the result register.
  assign s1_go    = s1_v_q && (!s1_last_q || out_free);
  assign in_ch_i.ready = !s1_v_q || s1_go;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr == ADDR_WARMUP);
  assign prdata = (paddr == ADDR_WARMUP) ? APB_DW'(warm_q) : '0;

  always_comb begin
    reg_cur  = s1_first_q ? s1_seed_q : prbs_q;
    ref_bit  = reg_cur[TAP_LO] ^ reg_cur[TAP_HI];
    prbs_d   = {reg_cur[PRBS_W-2:0], ref_bit};
    cnt_base = s1_first_q ? '0 : cnt_q;
    cnt_new  = cnt_base;
    if ((ref_bit != s1_rx_q) && (cnt_base < ERR_CAP)) begin
      cnt_new = cnt_base + CNT_W'(1);
    end

    err_sum   = {1'b0, err_tot_q} + {{(TOT_W-CNT_W+1){1'b0}}, cnt_new};
    blk_sum   = {1'b0, blk_tot_q} + (TOT_W+1)'(1);
    skip_d    = skip_q;
    err_tot_d = err_tot_q;
    blk_tot_d = blk_tot_q;
    counted   = 1'b0;
    cnt_d     = cnt_new;
    if (s1_last_q) begin
      cnt_d = '0;
      if (skip_q != '0) begin
        skip_d = skip_q - WARM_W'(1);
      end else begin
        counted   = 1'b1;
        err_tot_d = err_sum[TOT_W] ? TOT_MAX : err_sum[TOT_W-1:0];
        blk_tot_d = blk_sum[TOT_W] ? TOT_MAX : blk_sum[TOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      ov_q      <= 1'b0;
      prbs_q    <= '0;
      cnt_q     <= '0;
      warm_q    <= WARMUP_RESET;
      skip_q    <= WARMUP_RESET;
      err_tot_q <= '0;
      blk_tot_q <= '0;
    end else begin
      if (in_ch_i.ready) begin
        s1_v_q <= in_ch_i.valid;
      end
      if (s1_go) begin
        prbs_q <= prbs_d;
        cnt_q  <= cnt_d;
        err_tot_q <= err_tot_d;
        blk_tot_q <= blk_tot_d;
      end
      if (s1_go && s1_last_q) begin
        ov_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        ov_q <= 1'b0;
      end
      // A warm-up write restarts the skip countdown.
      if (cfg_wr) begin
        warm_q <= pwdata[WARM_W-1:0];
        skip_q <= pwdata[WARM_W-1:0];
      end else if (s1_go) begin
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      s1_rx_q    <= in_ch_i.rx_bit;
      s1_seed_q  <= in_ch_i.block_seed;
      s1_first_q <= in_ch_i.first_of_block;
      s1_last_q  <= in_ch_i.last_of_block;
    end
    if (s1_go && s1_last_q) begin
      o_err_q <= cnt_new;
      o_cnt_q <= counted;
    end
  end

  assign out_ch_o.valid          = ov_q;
  assign out_ch_o.block_errors   = o_err_q;
  assign out_ch_o.block_counted  = o_cnt_q;
  assign out_ch_o.total_errors   = err_tot_q;
  assign out_ch_o.counted_blocks = blk_tot_q;

endmodule

`default_nettype wire

@@ design/pbec_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pbec_checker
  import pbec_pkg::*;
(
  input wire             clk_i,
  input wire             rst_ni,
  input wire             out_valid,
  input wire             out_ready,
  input wire [CNT_W-1:0] block_errors,
  input wire             block_counted,
  input wire [TOT_W-1:0] total_errors,
  input wire [TOT_W-1:0] counted_blocks
);

  // A pending result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(block_errors) && $stable(block_counted)
                                && $stable(total_errors) && $stable(counted_blocks))
    else $error("result beat changed while stalled");

  // A block that went into the totals has been counted at least once.
  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && block_counted |-> counted_blocks != '0)
    else $error("counted block reported with zero block total");

  // The error total includes the errors of a counted block, or has saturated.
  a_total_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && block_counted |-> total_errors >= {{(TOT_W-CNT_W){1'b0}}, block_errors})
    else $error("error total below block errors of a counted block");

endmodule

bind prbs9_bit_error_checker_unit pbec_checker u_pbec_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_ch_o.valid),
  .out_ready      (out_ch_o.ready),
  .block_errors   (out_ch_o.block_errors),
  .block_counted  (out_ch_o.block_counted),
  .total_errors   (out_ch_o.total_errors),
  .counted_blocks (out_ch_o.counted_blocks)
);

`default_nettype wire
